// ===== sv/byte_histogram_first_seen_order_macros.svh =====
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef BYTE_HISTOGRAM_FIRST_SEEN_ORDER_MACROS_SVH
`define BYTE_HISTOGRAM_FIRST_SEEN_ORDER_MACROS_SVH

`ifndef SYNTH
`define BHFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BHFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BHFS_ASSERT_SAME(lbl, ante, cons, msg)
`define BHFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/bhfs_pkg.sv =====
package bhfs_pkg;

    localparam int NUM_SYMBOLS = 256;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 9;
    localparam int OCC_W       = 32;
    localparam int COUNT_BITS  = 32;   // counter width, 8..64

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [OCC_W-1:0]      OCC_MAX = '1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        CMD_COUNT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // latch input word
        logic ctr_rd_in;   // read counter at input byte
        logic ord_rd;      // read order store at input rank
        logic clear;       // forget all bytes
        logic cnt_upd;     // write back counter, append if new
        logic ctr_rd_sym;  // read counter at symbol from order store
        logic load_out;    // load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic [OCC_W-1:0] occ_sat(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        if (w > 64'(OCC_MAX)) begin
            return OCC_MAX;
        end
        return w[OCC_W-1:0];
    endfunction

endpackage

// ===== sv/bhfs_ctrl.sv =====
module bhfs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_tuser,
    input  bhfs_pkg::dp_stat_t stat,
    output bhfs_pkg::dp_cmd_t  ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CNT_UPD,
        ST_RD_SYM,
        ST_RD_CNT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;
    logic   accept;

    assign s_tready = s_tready_reg;
    assign accept   = s_tvalid && s_tready_reg;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.take = 1'b1;
                    case (s_tuser)
                        bhfs_pkg::CMD_COUNT: begin
                            ctrl.ctr_rd_in = 1'b1;
                            state_next     = ST_CNT_UPD;
                        end
                        bhfs_pkg::CMD_READ: begin
                            ctrl.ord_rd = 1'b1;
                            state_next  = ST_RD_SYM;
                        end
                        bhfs_pkg::CMD_CLEAR: begin
                            ctrl.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CNT_UPD: begin
                ctrl.cnt_upd = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RD_SYM: begin
                ctrl.ctr_rd_sym = 1'b1;
                state_next      = ST_RD_CNT;
            end
            ST_RD_CNT: begin
                // hold until the result register can take the word
                if (stat.out_free) begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// ===== sv/bhfs_datapath.sv =====
module bhfs_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [bhfs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  bhfs_pkg::dp_cmd_t                  ctrl,
    output bhfs_pkg::dp_stat_t                 stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bhfs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);

    localparam int SW = bhfs_pkg::SYM_W;
    localparam int CW = bhfs_pkg::COUNT_BITS;
    localparam int DW = bhfs_pkg::DIST_W;
    localparam int OW = bhfs_pkg::OCC_W;
    localparam int N  = bhfs_pkg::NUM_SYMBOLS;

    logic [N-1:0]  seen_reg;
    logic [DW-1:0] distinct_reg;
    logic [SW-1:0] byte_reg;
    logic [SW-1:0] rank_reg;

    logic [CW-1:0] ctr_mem [N];
    logic [CW-1:0] ctr_q;
    logic [SW-1:0] ord_mem [N];
    logic [SW-1:0] ord_q;

    logic [SW-1:0] in_byte, in_rank;
    logic [SW-1:0] ctr_rd_addr;
    logic          ctr_rd_en;
    logic          is_seen;
    logic          room;
    logic [CW-1:0] ctr_new;
    logic          found;

    logic          m_tvalid_reg;
    logic [SW-1:0] sym_out_reg;
    logic [OW-1:0] occ_out_reg;
    logic          found_out_reg;
    logic [DW-1:0] dist_out_reg;

    assign in_byte = s_tdata[SW-1:0];
    assign in_rank = s_tdata[2*SW-1:SW];

    assign ctr_rd_addr = ctrl.ctr_rd_in ? in_byte : ord_q;
    assign ctr_rd_en   = ctrl.ctr_rd_in || ctrl.ctr_rd_sym;

    assign is_seen = seen_reg[byte_reg];
    assign room    = distinct_reg < DW'(N);
    assign ctr_new = !is_seen ? CW'(1) :
                     (ctr_q == bhfs_pkg::CNT_MAX) ? ctr_q : ctr_q + CW'(1);
    assign found   = {1'b0, rank_reg} < distinct_reg;

    assign stat.out_free = !m_tvalid_reg || m_tready;

    // counter store: one read port, one write port
    always_ff @(posedge aclk) begin
        if (ctrl.cnt_upd) begin
            ctr_mem[byte_reg] <= ctr_new;
        end
        if (ctr_rd_en) begin
            ctr_q <= ctr_mem[ctr_rd_addr];
        end
    end

    // first-seen order store
    always_ff @(posedge aclk) begin
        if (ctrl.cnt_upd && !is_seen && room) begin
            ord_mem[distinct_reg[SW-1:0]] <= byte_reg;
        end
        if (ctrl.ord_rd) begin
            ord_q <= ord_mem[in_rank];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.take) begin
            byte_reg <= in_byte;
            rank_reg <= in_rank;
        end
        if (ctrl.load_out) begin
            sym_out_reg   <= found ? ord_q : '0;
            occ_out_reg   <= found ? bhfs_pkg::occ_sat(ctr_q) : '0;
            found_out_reg <= found;
            dist_out_reg  <= distinct_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            distinct_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                seen_reg     <= '0;
                distinct_reg <= '0;
            end else if (ctrl.cnt_upd && !is_seen) begin
                seen_reg[byte_reg] <= 1'b1;
                if (room) begin
                    distinct_reg <= distinct_reg + DW'(1);
                end
            end
            if (ctrl.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_out_reg;
    assign m_tdata  = bhfs_pkg::M_TDATA_W'({dist_out_reg, occ_out_reg, sym_out_reg});

endmodule

// ===== sv/byte_histogram_first_seen_order.sv =====
// Byte histogram with first-seen order. Each input word carries a command in
// s_tuser: count a byte (adds one to its saturating counter; a new byte starts
// at one and is appended to the first-seen list), read by first-seen rank
// (returns one result word), or clear (forgets every byte at once; code 3 is ignored).
// A count reads the counter memory, then writes it back; a read reads the order
// store, then the counter, then loads the result; clear and the unused code
// need no further step. The single read port of the counter memory sets these steps.
// A read whose result register is still full waits until m_tready frees it;
// other commands are accepted while a result waits. No start-up clearing pass.
`include "byte_histogram_first_seen_order_macros.svh"

module byte_histogram_first_seen_order (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bhfs_pkg::S_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], rank[15:8]
    input  logic [1:0]                      s_tuser,   // cmd[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bhfs_pkg::M_TDATA_W-1:0]  m_tdata,   // symbol[7:0], occurrences[39:8],
                                                       // distinct_total[48:40], zero pad
    output logic                            m_tuser    // found
);

    bhfs_pkg::dp_cmd_t  ctrl;
    bhfs_pkg::dp_stat_t stat;

    bhfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bhfs_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `BHFS_ASSERT_SAME(a_no_overwrite, ctrl.load_out, !m_tvalid || m_tready, "result overwritten")
    `BHFS_ASSERT_SAME(a_found_nonzero, m_tvalid && m_tuser, m_tdata[48:40] != 9'd0 && m_tdata[39:8] != 32'd0, "found entry with zero count")
    `BHFS_ASSERT_SAME(a_dist_range, m_tvalid, m_tdata[48:40] <= 9'd256, "distinct total out of range")
    `BHFS_ASSERT_NEXT(a_count_busy, s_tvalid && s_tready && s_tuser == bhfs_pkg::CMD_COUNT, !s_tready && ctrl.cnt_upd, "count update missing")

endmodule

// ===== verif/byte_histogram_first_seen_order_tb.sv =====
module byte_histogram_first_seen_order_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET  = 1350;
    localparam int         FILL_ITEMS   = 320;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         REPORT_LIMIT = 10;
    localparam int         CW           = bhfs_pkg::COUNT_BITS;
    localparam int         DW           = bhfs_pkg::DIST_W;

    typedef struct {
        bit [bhfs_pkg::SYM_W-1:0]  symbol;
        bit [bhfs_pkg::OCC_W-1:0]  occurrences;
        bit                        found;
        bit [bhfs_pkg::DIST_W-1:0] distinct_total;
    } rank_reply_t;

    // Tracks the histogram and the first-seen list, and queues the reply
    // that each accepted read word must produce.
    class byte_tally_model;
        bit                           seen[bhfs_pkg::NUM_SYMBOLS];
        bit [bhfs_pkg::COUNT_BITS-1:0] tally[bhfs_pkg::NUM_SYMBOLS];
        bit [bhfs_pkg::SYM_W-1:0]     first_seen[bhfs_pkg::NUM_SYMBOLS];
        int unsigned                  distinct;
        rank_reply_t                  pending_reads[$];
        int unsigned                  mismatches;
        int unsigned                  replies_checked;
        int unsigned                  n_count, n_read, n_clear, n_unused, n_miss;
        int unsigned                  peak_distinct;

        function new();
            foreach (seen[i]) seen[i] = 1'b0;
            distinct = 0;
        endfunction

        function void note_word(logic [1:0] cmd, bit [7:0] data_byte, bit [7:0] rank);
            rank_reply_t r;
            bit [63:0]   wide;
            case (cmd)
                bhfs_pkg::CMD_COUNT: begin
                    n_count++;
                    if (seen[data_byte]) begin
                        if (tally[data_byte] != bhfs_pkg::CNT_MAX)
                            tally[data_byte] += CW'(1);
                    end else begin
                        seen[data_byte]  = 1'b1;
                        tally[data_byte] = CW'(1);
                        if (distinct < bhfs_pkg::NUM_SYMBOLS) begin
                            first_seen[distinct] = data_byte;
                            distinct++;
                        end
                    end
                    if (distinct > peak_distinct) peak_distinct = distinct;
                end
                bhfs_pkg::CMD_CLEAR: begin
                    n_clear++;
                    foreach (seen[i]) seen[i] = 1'b0;
                    distinct = 0;
                end
                bhfs_pkg::CMD_READ: begin
                    n_read++;
                    r.symbol = '0;
                    r.occurrences = '0;
                    r.found = 1'b0;
                    r.distinct_total = DW'(distinct);
                    if (rank < distinct) begin
                        r.symbol = first_seen[rank];
                        wide = 64'(tally[r.symbol]);
                        // wider counters clamp to the 32-bit output field
                        r.occurrences = (wide > 64'(bhfs_pkg::OCC_MAX)) ?
                                        bhfs_pkg::OCC_MAX : wide[bhfs_pkg::OCC_W-1:0];
                        r.found = 1'b1;
                    end else begin
                        n_miss++;
                    end
                    pending_reads.push_back(r);
                end
                default: n_unused++;
            endcase
        endfunction

        function void check_reply(logic [bhfs_pkg::M_TDATA_W-1:0] tdata, logic tuser);
            rank_reply_t exp_r;
            logic [bhfs_pkg::SYM_W-1:0]  got_sym;
            logic [bhfs_pkg::OCC_W-1:0]  got_occ;
            logic [bhfs_pkg::DIST_W-1:0] got_dist;
            got_sym  = tdata[7:0];
            got_occ  = tdata[39:8];
            got_dist = tdata[48:40];
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected reply: sym=%02h occ=%0d found=%b dist=%0d",
                             $realtime, got_sym, got_occ, tuser, got_dist);
                return;
            end
            exp_r = pending_reads.pop_front();
            replies_checked++;
            if (got_sym !== exp_r.symbol || got_occ !== exp_r.occurrences ||
                tuser !== exp_r.found || got_dist !== exp_r.distinct_total) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"[%0t] reply mismatch: exp sym=%02h occ=%0d found=%b dist=%0d,",
                              " got sym=%02h occ=%0d found=%b dist=%0d"},
                             $realtime, exp_r.symbol, exp_r.occurrences, exp_r.found,
                             exp_r.distinct_total, got_sym, got_occ, tuser, got_dist);
            end
        endfunction

        function int pending();
            return pending_reads.size();
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bhfs_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // data_byte[7:0], rank[15:8]
    logic [1:0]                     s_tuser  = '0;   // cmd[1:0]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // symbol[7:0], occurrences[39:8], distinct_total[48:40]
    logic [bhfs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;         // found

    byte_tally_model sb;
    int unsigned     items_sent;
    int              burst_left;
    bit              hold_req;
    bit              hold_active;

    byte_histogram_first_seen_order dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("run timed out with %0d replies outstanding", sb.pending());
        $display("FAILURE");
        $finish;
    end

    // Sender: bursts of random length, random gaps between them.
    task automatic offer_word(logic [1:0] cmd, bit [7:0] data_byte, bit [7:0] rank);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {rank, data_byte};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(cmd, data_byte, rank);
        items_sent++;
    endtask

    function automatic bit [7:0] pick_rank();
        int top;
        top = (sb.distinct >= bhfs_pkg::NUM_SYMBOLS) ? bhfs_pkg::NUM_SYMBOLS - 1 : sb.distinct;
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, top));
        return 8'($urandom_range(0, 255));
    endfunction

    // Counts from a small random alphabet so bytes repeat, with reads mixed in.
    task automatic run_stream();
        bit [7:0] alphabet[16];
        int       asize;
        int       len;
        asize = $urandom_range(1, 16);
        foreach (alphabet[i]) alphabet[i] = 8'($urandom);
        len = $urandom_range(5, 40);
        repeat (len) begin
            if ($urandom_range(0, 9) < 7)
                offer_word(bhfs_pkg::CMD_COUNT, alphabet[$urandom_range(0, asize - 1)],
                           8'($urandom));
            else
                offer_word(bhfs_pkg::CMD_READ, 8'($urandom), pick_rank());
        end
    endtask

    // Every byte value in shuffled order, then reads at the top ranks and rank 0.
    task automatic run_fill();
        bit [7:0] perm[bhfs_pkg::NUM_SYMBOLS];
        bit [7:0] tmp;
        int       j;
        foreach (perm[i]) perm[i] = 8'(i);
        for (int i = bhfs_pkg::NUM_SYMBOLS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        foreach (perm[i]) begin
            offer_word(bhfs_pkg::CMD_COUNT, perm[i], 8'($urandom));
            if ($urandom_range(0, 15) == 0)
                offer_word(bhfs_pkg::CMD_COUNT, perm[$urandom_range(0, i)], 8'($urandom));
            if ($urandom_range(0, 15) == 0)
                offer_word(bhfs_pkg::CMD_READ, 8'($urandom), pick_rank());
        end
        offer_word(bhfs_pkg::CMD_COUNT, 8'($urandom), 8'($urandom));
        offer_word(bhfs_pkg::CMD_READ, 8'($urandom), 8'd255);
        offer_word(bhfs_pkg::CMD_READ, 8'($urandom), 8'd254);
        offer_word(bhfs_pkg::CMD_READ, 8'($urandom), 8'd0);
        repeat (6) offer_word(bhfs_pkg::CMD_READ, 8'($urandom), 8'($urandom));
    endtask

    task automatic run_directed();
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'h00);   // empty histogram
        offer_word(bhfs_pkg::CMD_READ,  8'hFF, 8'hFF);
        offer_word(bhfs_pkg::CMD_COUNT, 8'h00, 8'h00);
        offer_word(bhfs_pkg::CMD_COUNT, 8'hFF, 8'hFF);
        offer_word(bhfs_pkg::CMD_COUNT, 8'h00, 8'h55);
        offer_word(bhfs_pkg::CMD_COUNT, 8'hA5, 8'h00);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd0);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd1);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd2);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd3);    // one past the end
        offer_word(CMD_UNUSED,          8'h3C, 8'h80);   // must leave state alone
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd3);
        offer_word(bhfs_pkg::CMD_READ,  8'hFF, 8'd0);
        offer_word(bhfs_pkg::CMD_CLEAR, 8'hFF, 8'hFF);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd0);
        // old counter for 0xFF is stale and must restart at one
        offer_word(bhfs_pkg::CMD_COUNT, 8'hFF, 8'h00);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd0);
        offer_word(bhfs_pkg::CMD_COUNT, 8'h5A, 8'hFF);
        offer_word(bhfs_pkg::CMD_READ,  8'hFF, 8'd1);
        offer_word(bhfs_pkg::CMD_READ,  8'h00, 8'd255);
    endtask

    // Receiver: runs of always-ready, half, sparse and mostly-ready, plus one long hold.
    initial begin : receiver
        int mode;
        int span;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span) begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser);
    end

    initial begin : stimulus
        int pick;
        int fills;
        sb = new();
        items_sent = 0;
        burst_left = 0;
        fills = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // read-heavy flood while the receiver holds off, so the input backs up
        s_tvalid <= 1'b0;
        hold_req = 1'b1;
        @(posedge aclk);
        wait (hold_active);
        burst_left = 40;
        repeat (36) begin
            if ($urandom_range(0, 3) == 0)
                offer_word(bhfs_pkg::CMD_COUNT, 8'($urandom), 8'($urandom));
            else
                offer_word(bhfs_pkg::CMD_READ, 8'($urandom), pick_rank());
        end

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (fills == 0 && items_sent > 500) begin
                run_fill();
                fills++;
            end else if (pick < 2 && fills < 2 && items_sent + FILL_ITEMS < ITEM_TARGET) begin
                run_fill();
                fills++;
            end else if (pick < 9) begin
                offer_word(bhfs_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
            end else if (pick < 12) begin
                offer_word(CMD_UNUSED, 8'($urandom), 8'($urandom));
            end else begin
                run_stream();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words: %0d counts, %0d reads (%0d past the end),",
                 items_sent, sb.n_count, sb.n_read, sb.n_miss);
        $display("%0d clears, %0d unused; replies checked %0d, peak distinct bytes %0d",
                 sb.n_clear, sb.n_unused, sb.replies_checked, sb.peak_distinct);
        $display("mismatches %0d, outstanding %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
